// ===== sv/ssbb_pkg.sv =====
// Shared types, constants and tables for the seven-segment blink buffer.
package ssbb_pkg;

    localparam int SEG_BYTES  = 9;
    localparam int DIGITS     = 4;
    localparam int GLYPHS     = 40;
    localparam int GLYPH_SEGS = 7;

    localparam int IDX_W   = (SEG_BYTES > 1) ? $clog2(SEG_BYTES) : 1;
    localparam int SEG_W   = 7;
    localparam int REG_W   = 4;
    localparam int STEP_W  = 3;
    localparam int PLANES  = 2;

    localparam logic [7:0] PERIOD_RESET = 8'd12;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_P1  = 2'd1;
    localparam logic [1:0] MODE_P2  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_PRINT = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_FILL  = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_FLAG,
        S_CMP,
        S_ONE,
        S_EMIT
    } t_state;

    // Command from the sequencer to the plane store.
    typedef struct packed {
        logic             wr_en;
        logic             fill_en;
        logic [IDX_W-1:0] addr;
        logic [2:0]       bit_sel;
        logic [1:0]       plane_bits;
    } t_st_cmd;

    // Bytes of both planes at the addressed register.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
    } t_st_rd;

    localparam logic [7:0] GLYPH_ROM [GLYPHS] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h63, 8'h54, 8'h73, 8'h76,
        8'h30, 8'h08, 8'h40, 8'h01, 8'h48, 8'h41, 8'h09, 8'h49, 8'h50, 8'h54,
        8'h10, 8'h5C, 8'h00, 8'h33, 8'h27, 8'h38, 8'h58, 8'h3E, 8'h78, 8'h6E
    };

    // Segment number of element F for each digit field.
    localparam logic [SEG_W-1:0] FIELD_BASE [DIGITS] = '{
        7'd40, 7'd36, 7'd31, 7'd27
    };

    // Offset of segments A..G from element F.
    function automatic logic [SEG_W-1:0] seg_offset(input logic [STEP_W-1:0] step);
        logic [SEG_W-1:0] off;
        case (step)
            3'd0:    off = 7'd2;
            3'd1:    off = 7'd3;
            3'd2:    off = 7'd27;
            3'd3:    off = 7'd25;
            3'd4:    off = 7'd24;
            3'd5:    off = 7'd0;
            3'd6:    off = 7'd1;
            default: off = 7'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== sv/seven_segment_blink_buffer.sv =====
// Top level of the seven-segment blink buffer: config register, sequencer and plane store.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one command beat: print a glyph
//   into a digit field, set one segment, fill both planes, or a frame tick.
//   Output channel (o_out_valid / i_out_ready) returns result beats; o_last marks
//   the final beat of each command. A due tick returns nine beats, one per display
//   register, from the active plane; every other command returns one empty beat.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the blink period; always ready.
// Sequencing:
//   A set writes one segment, a print seven, in S_WRITE; S_FLAG may then compare
//   the planes one byte per cycle through the shared compare. Fill and non-due ticks
//   go straight to their beat; a due tick emits one beat per cycle while i_out_ready
//   is high. One command is in flight at a time; o_in_ready is high only when idle.
// Reset clears both planes, the blink counter and flags, and sets the period to 12.
// A stalled receiver holds the current beat; the block waits and accepts nothing.
module seven_segment_blink_buffer
    import ssbb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_blink_period_frames,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_func,
    input  logic [6:0]       i_value,
    input  logic [1:0]       i_digit_pos,
    input  logic [1:0]       i_mode,
    input  logic             i_force_update,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_write_valid,
    output logic [REG_W-1:0] o_reg_index,
    output logic [7:0]       o_seg_byte,
    output logic             o_last,
    output logic             o_tick_enable
);

    logic [7:0] r_period;
    t_st_cmd    w_cmd;
    t_st_rd     w_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_period <= i_cfg_blink_period_frames;
        end
    end

    ssbb_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_digit_pos    (i_digit_pos),
        .i_mode         (i_mode),
        .i_force_update (i_force_update),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_write_valid  (o_write_valid),
        .o_reg_index    (o_reg_index),
        .o_seg_byte     (o_seg_byte),
        .o_last         (o_last),
        .o_tick_enable  (o_tick_enable),
        .i_period       (r_period),
        .o_cmd          (w_cmd),
        .i_rd           (w_rd)
    );

    ssbb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rd    (w_rd)
    );

endmodule

// ===== sv/ssbb_store.sv =====
// Two bitplanes of segment bytes with a bit read-modify-write and fill port.
module ssbb_store
    import ssbb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_st_cmd i_cmd,
    output t_st_rd  o_rd
);

    logic [7:0] r_plane [PLANES][SEG_BYTES];
    logic [7:0] w_mask;

    assign w_mask = 8'd1 << i_cmd.bit_sel;

    assign o_rd.byte0 = r_plane[0][i_cmd.addr];
    assign o_rd.byte1 = r_plane[1][i_cmd.addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANES; p++) begin
                for (int i = 0; i < SEG_BYTES; i++) begin
                    r_plane[p][i] <= '0;
                end
            end
        end else if (i_cmd.fill_en) begin
            for (int p = 0; p < PLANES; p++) begin
                for (int i = 0; i < SEG_BYTES; i++) begin
                    r_plane[p][i] <= {8{i_cmd.plane_bits[p]}};
                end
            end
        end else if (i_cmd.wr_en) begin
            for (int p = 0; p < PLANES; p++) begin
                if (i_cmd.plane_bits[p]) begin
                    r_plane[p][i_cmd.addr] <= r_plane[p][i_cmd.addr] | w_mask;
                end else begin
                    r_plane[p][i_cmd.addr] <= r_plane[p][i_cmd.addr] & ~w_mask;
                end
            end
        end
    end

endmodule

// ===== sv/ssbb_seq.sv =====
// Command sequencer: segment writes, plane compare, blink timing and beat output.
module ssbb_seq
    import ssbb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_func,
    input  logic [6:0]       i_value,
    input  logic [1:0]       i_digit_pos,
    input  logic [1:0]       i_mode,
    input  logic             i_force_update,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_write_valid,
    output logic [REG_W-1:0] o_reg_index,
    output logic [7:0]       o_seg_byte,
    output logic             o_last,
    output logic             o_tick_enable,
    input  logic [7:0]       i_period,
    output t_st_cmd          o_cmd,
    input  t_st_rd           i_rd
);

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SEG_BYTES - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GLYPH_SEGS - 1);

    t_state              r_state, n_state;
    t_func               r_func, n_func;
    logic [6:0]          r_value, n_value;
    logic [1:0]          r_pos, n_pos;
    logic [1:0]          r_mode, n_mode;
    logic [7:0]          r_glyph, n_glyph;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic [7:0]          r_blink, n_blink;
    logic                r_active, n_active;
    logic                r_pending, n_pending;
    logic                r_differ, n_differ;

    logic                w_in_acc;
    logic                w_out_acc;
    logic [SEG_W-1:0]    w_seg;
    logic [1:0]          w_seg_mode;
    logic                w_seg_ok;
    logic                w_last_step;
    logic [7:0]          w_blink_inc;
    logic                w_toggle;
    logic                w_glyph_ok;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    assign w_seg = (r_func == FUNC_PRINT) ? FIELD_BASE[r_pos] + seg_offset(r_step) : r_value;
    assign w_seg_mode = ((r_func == FUNC_SET) || r_glyph[r_step]) ? r_mode : MODE_OFF;
    assign w_seg_ok = (w_seg[SEG_W-1:3] < (SEG_W-3)'(SEG_BYTES));
    assign w_last_step = (r_func == FUNC_SET) || (r_step == LAST_STEP);

    assign w_blink_inc = r_blink + 8'd1;
    assign w_toggle    = w_blink_inc > i_period;
    assign w_glyph_ok  = (i_value < 7'(GLYPHS)) && (i_digit_pos < 2'(DIGITS - 1) + 2'd1
                         || DIGITS > 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_blink   <= '0;
            r_active  <= 1'b0;
            r_pending <= 1'b0;
            r_differ  <= 1'b0;
            r_step    <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_blink   <= n_blink;
            r_active  <= n_active;
            r_pending <= n_pending;
            r_differ  <= n_differ;
            r_step    <= n_step;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_mode  <= n_mode;
        r_glyph <= n_glyph;
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_value   = r_value;
        n_pos     = r_pos;
        n_mode    = r_mode;
        n_glyph   = r_glyph;
        n_step    = r_step;
        n_cnt     = r_cnt;
        n_blink   = r_blink;
        n_active  = r_active;
        n_pending = r_pending;
        n_differ  = r_differ;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_func  = t_func'(i_func);
                    n_value = i_value;
                    n_pos   = i_digit_pos;
                    n_mode  = i_mode;
                    n_glyph = (i_value < 7'(GLYPHS)) ? GLYPH_ROM[i_value[5:0]] : 8'd0;
                    n_step  = '0;
                    n_cnt   = '0;
                    unique case (t_func'(i_func))
                        FUNC_PRINT: n_state = w_glyph_ok ? S_WRITE : S_FLAG;
                        FUNC_SET:   n_state = S_WRITE;
                        FUNC_FILL: begin
                            n_differ  = 1'b0;
                            n_pending = 1'b1;
                            n_state   = S_ONE;
                        end
                        FUNC_TICK: begin
                            n_blink = w_toggle ? 8'd0 : w_blink_inc;
                            if (w_toggle) begin
                                n_active = ~r_active;
                            end
                            if (w_toggle || i_force_update || r_pending) begin
                                n_pending = 1'b0;
                                n_state   = S_EMIT;
                            end else begin
                                n_state = S_ONE;
                            end
                        end
                        default: n_state = S_ONE;
                    endcase
                end
            end
            S_WRITE: begin
                if (w_last_step) begin
                    n_state = S_FLAG;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_FLAG: begin
                if (r_mode == MODE_P1 || r_mode == MODE_P2) begin
                    n_differ = 1'b1;
                    n_state  = S_ONE;
                end else if (r_mode == MODE_OFF && !r_differ) begin
                    n_state = S_ONE;
                end else begin
                    n_cnt   = '0;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_rd.byte0 != i_rd.byte1) begin
                    n_differ = 1'b1;
                    n_state  = S_ONE;
                end else if (r_cnt == LAST_IDX) begin
                    n_differ = 1'b0;
                    n_state  = S_ONE;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_ONE: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    if (r_cnt == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + IDX_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_out_valid   = (r_state == S_ONE) || (r_state == S_EMIT);
        o_write_valid = (r_state == S_EMIT);
        o_reg_index   = (r_state == S_EMIT) ? REG_W'(r_cnt) : '0;
        o_seg_byte    = '0;
        if (r_state == S_EMIT) begin
            o_seg_byte = r_active ? i_rd.byte1 : i_rd.byte0;
        end
        o_last        = (r_state == S_ONE) || (r_cnt == LAST_IDX);
        o_tick_enable = r_differ || r_pending;

        o_cmd.wr_en      = (r_state == S_WRITE) && w_seg_ok;
        o_cmd.fill_en    = w_in_acc && (t_func'(i_func) == FUNC_FILL);
        o_cmd.bit_sel    = w_seg[2:0];
        o_cmd.plane_bits = o_cmd.fill_en ? i_mode : w_seg_mode;
        o_cmd.addr       = r_cnt;
        if (r_state == S_WRITE) begin
            o_cmd.addr = w_seg_ok ? IDX_W'(w_seg[SEG_W-1:3]) : '0;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output sides active together");

    a_fill_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && t_func'(i_func) == FUNC_FILL) |=> (r_pending && !r_differ))
        else $error("fill did not set pending and clear differ");

    a_last_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_valid && o_last) |-> (o_reg_index == REG_W'(SEG_BYTES - 1)))
        else $error("last beat on wrong register");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_pending)
        else $error("pending update left set while emitting");

endmodule
